>>> rtl/core/chacha_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 package
// Shared types, constants and helper functions of the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package chacha_pkg;

  localparam int unsigned RoundCountDefault = 20;
  localparam int unsigned RegWidth  = 64;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned WordCount = 16;

  localparam logic [RegIdxW-1:0] RegKey0  = 3'd0;
  localparam logic [RegIdxW-1:0] RegKey1  = 3'd1;
  localparam logic [RegIdxW-1:0] RegKey2  = 3'd2;
  localparam logic [RegIdxW-1:0] RegKey3  = 3'd3;
  localparam logic [RegIdxW-1:0] RegNonce = 3'd4;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StRound,
    StFinal,
    StOut
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;  // take the input byte
    logic       load;     // copy the initial state into the working words
    logic       qr_en;    // run one quarter-round
    logic       finish;   // feed-forward add, advance the counter
    logic       emit;     // form the output byte, advance the position
    logic       clear;    // clear counter and position
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_block;
    logic rounds_done;
  } status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

endpackage

>>> rtl/core/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher
// XORs each byte with the next ChaCha20 keystream byte (64-bit nonce layout).
// ----------------------------------------------------------------------------
// With the output ready, a byte that reuses the current keystream block passes
// from StLoad to StOut, where its result is registered, and the next byte is
// accepted once the controller is back in StIdle. A byte that starts a block
// (position zero or tuser set) waits for a new block from one shared
// quarter-round unit: 4 * ROUND_COUNT quarter-rounds, one per cycle, plus load
// and feed-forward, through StLoad, StRound and StFinal, before its result is
// formed in StOut. A result that waits on m_axis_tready holds up the following
// byte. Writing any valid register restarts the keystream at counter zero.
module chacha20_stream_cipher #(
  parameter int unsigned ROUND_COUNT = chacha_pkg::RoundCountDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // data_byte
  input  logic                               s_axis_tuser,  // start_of_call
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // out_byte
  input  logic                               cfg_we_i,
  input  logic [chacha_pkg::RegIdxW-1:0]     cfg_addr_i,
  input  logic [chacha_pkg::RegWidth-1:0]    cfg_wdata_i
);
  import chacha_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_hit;

  chacha_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .cfg_hit_i(cfg_hit), .status_i(status), .cmd_o(cmd)
  );

  chacha_dp #(.ROUND_COUNT(ROUND_COUNT)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .data_i(s_axis_tdata), .start_i(s_axis_tuser), .cmd_i(cmd),
    .status_o(status), .cfg_hit_o(cfg_hit), .out_byte_o(m_axis_tdata)
  );

endmodule

>>> rtl/core/chacha_ctrl.sv
// ----------------------------------------------------------------------------
// ChaCha20 controller
// Sequences byte intake, block generation and output delivery.
// ----------------------------------------------------------------------------
module chacha_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_hit_i,
  input  chacha_pkg::status_t status_i,
  output chacha_pkg::cmd_t    cmd_o
);
  import chacha_pkg::*;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (s_axis_tvalid) state_d = StLoad;
      StLoad:  state_d = status_i.need_block ? StRound : StOut;
      StRound: if (status_i.rounds_done) state_d = StFinal;
      StFinal: state_d = StOut;
      StOut:   if (!ovalid_q || m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = (state_q == StIdle);
    cmd_o.capture = (state_q == StIdle) && s_axis_tvalid;
    cmd_o.load    = (state_q == StLoad) && status_i.need_block;
    cmd_o.qr_en   = (state_q == StRound);
    cmd_o.finish  = (state_q == StFinal);
    cmd_o.emit    = (state_q == StOut) && (!ovalid_q || m_axis_tready);
    cmd_o.clear   = cfg_hit_i;
    m_axis_tvalid = ovalid_q;
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (m_axis_tready) ovalid_d = 1'b0;
    if (cmd_o.emit) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_emit_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> state_q == StOut) else $error("emit outside output state");
  a_round_follows_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == StRound) else $error("load not followed by rounds");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !s_axis_tready) else $error("ready while busy");

endmodule

>>> rtl/core/chacha_dp.sv
// ----------------------------------------------------------------------------
// ChaCha20 datapath
// Configuration registers, block state and one shared quarter-round unit.
// ----------------------------------------------------------------------------
module chacha_dp #(
  parameter int unsigned ROUND_COUNT = chacha_pkg::RoundCountDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [chacha_pkg::RegIdxW-1:0]      cfg_addr_i,
  input  logic [chacha_pkg::RegWidth-1:0]     cfg_wdata_i,
  input  logic [7:0]                          data_i,
  input  logic                                start_i,
  input  chacha_pkg::cmd_t                    cmd_i,
  output chacha_pkg::status_t                 status_o,
  output logic                                cfg_hit_o,
  output logic [7:0]                          out_byte_o
);
  import chacha_pkg::*;

  localparam int unsigned QrTotal = 4 * ROUND_COUNT;
  localparam int unsigned QrW     = $clog2(QrTotal + 1);

  logic [63:0] key_q [4];
  logic [63:0] nonce_q;
  logic [63:0] ctr_q;
  logic [5:0]  pos_q;
  logic [7:0]  data_q;
  logic        start_q;
  logic [31:0] work_q [WordCount];
  logic [31:0] ks_q   [WordCount];
  logic [31:0] init_w [WordCount];
  logic [QrW-1:0] qr_cnt_q;
  logic [7:0]  obyte_q;

  logic [3:0]  ia, ib, ic, id;
  logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;
  logic [5:0]  cur_pos;
  logic [31:0] ks_word;
  logic        diag;
  logic [1:0]  lane;

  assign cfg_hit_o = cfg_we_i && (cfg_addr_i <= RegNonce);

  always_comb begin
    init_w[0] = Sigma0;
    init_w[1] = Sigma1;
    init_w[2] = Sigma2;
    init_w[3] = Sigma3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = key_q[i][31:0];
      init_w[5 + 2 * i] = key_q[i][63:32];
    end
    init_w[12] = ctr_q[31:0];
    init_w[13] = ctr_q[63:32];
    init_w[14] = nonce_q[31:0];
    init_w[15] = nonce_q[63:32];
  end

  // Quarter-round indices: bits [1:0] of the count pick the lane, bit 2 a column or diagonal round.
  assign lane = qr_cnt_q[1:0];
  assign diag = qr_cnt_q[2];
  always_comb begin
    ia = {2'b00, lane};
    ib = {2'b01, diag ? lane + 2'd1 : lane};
    ic = {2'b10, diag ? lane + 2'd2 : lane};
    id = {2'b11, diag ? lane + 2'd3 : lane};
  end

  always_comb begin
    a0 = work_q[ia] + work_q[ib];
    d0 = rotl32(work_q[id] ^ a0, 16);
    c0 = work_q[ic] + d0;
    b0 = rotl32(work_q[ib] ^ c0, 12);
    a1 = a0 + b0;
    d1 = rotl32(d0 ^ a1, 8);
    c1 = c0 + d1;
    b1 = rotl32(b0 ^ c1, 7);
    a2 = a1; b2 = b1; c2 = c1; d2 = d1;
  end

  assign status_o.need_block  = start_q || (pos_q == 6'd0);
  assign status_o.rounds_done = (qr_cnt_q == QrW'(QrTotal - 1));

  assign cur_pos = start_q ? 6'd0 : pos_q;
  assign ks_word = ks_q[cur_pos[5:2]];
  assign out_byte_o = obyte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      nonce_q  <= '0;
      ctr_q    <= '0;
      pos_q    <= '0;
      qr_cnt_q <= '0;
      start_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) start_q <= start_i;
      if (cmd_i.load) qr_cnt_q <= '0;
      else if (cmd_i.qr_en) qr_cnt_q <= qr_cnt_q + 1'b1;
      if (cmd_i.finish) ctr_q <= ctr_q + 64'd1;
      if (cmd_i.emit) begin
        pos_q   <= cur_pos + 6'd1;
        start_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegKey0:  key_q[0] <= cfg_wdata_i;
          RegKey1:  key_q[1] <= cfg_wdata_i;
          RegKey2:  key_q[2] <= cfg_wdata_i;
          RegKey3:  key_q[3] <= cfg_wdata_i;
          RegNonce: nonce_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.clear) begin
        ctr_q <= '0;
        pos_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) data_q <= data_i;
    if (cmd_i.load) begin
      for (int i = 0; i < WordCount; i++) work_q[i] <= init_w[i];
    end else if (cmd_i.qr_en) begin
      work_q[ia] <= a2;
      work_q[ib] <= b2;
      work_q[ic] <= c2;
      work_q[id] <= d2;
    end
    if (cmd_i.finish) begin
      for (int i = 0; i < WordCount; i++) ks_q[i] <= work_q[i] + init_w[i];
    end
    if (cmd_i.emit) obyte_q <= data_q ^ ks_word[{cur_pos[1:0], 3'b000} +: 8];
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qr_cnt_q <= QrW'(QrTotal)) else $error("round counter overrun");
  a_ctr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && !cmd_i.clear |=> ctr_q == $past(ctr_q) + 64'd1)
    else $error("counter not advanced");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> pos_q == 6'd0 && ctr_q == 64'd0) else $error("clear failed");

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher testbench
// Drives bytes through the stream interface, predicts each output byte with
// an independent keystream model and checks every transaction in order.
// ----------------------------------------------------------------------------
module tb;
  import chacha_pkg::*;

  localparam int unsigned Rounds   = RoundCountDefault;
  localparam int unsigned BlockLat = 3 + 4 * Rounds;
  localparam int unsigned Watchdog = 20 * BlockLat + 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [RegIdxW-1:0]  cfg_addr_i = '0;
  logic [RegWidth-1:0] cfg_wdata_i = '0;

  chacha20_stream_cipher #(.ROUND_COUNT(Rounds)) i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [63:0] key_q [4];
  logic [63:0] nonce_q;
  logic [63:0] ctr_q;
  logic [5:0]  pos_q;
  logic [31:0] ks_q [16];

  logic [7:0] expected_bytes [$];
  int  mismatches;
  int  idle_cycles;
  int  ready_gap = 0;
  bit  quiet;
  bit  timed_out;

  function automatic logic [31:0] rol(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic qround(inout logic [31:0] w [16], input int a, b, c, d);
    w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 16);
    w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 12);
    w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 8);
    w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 7);
  endtask

  task automatic build_keystream_block();
    logic [31:0] init [16];
    logic [31:0] w [16];
    init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2*i] = key_q[i][31:0];
      init[5 + 2*i] = key_q[i][63:32];
    end
    init[12] = ctr_q[31:0];  init[13] = ctr_q[63:32];
    init[14] = nonce_q[31:0]; init[15] = nonce_q[63:32];
    w = init;
    for (int r = 0; r < Rounds; r++) begin
      if (r % 2 == 0) begin
        qround(w, 0, 4, 8, 12); qround(w, 1, 5, 9, 13);
        qround(w, 2, 6, 10, 14); qround(w, 3, 7, 11, 15);
      end else begin
        qround(w, 0, 5, 10, 15); qround(w, 1, 6, 11, 12);
        qround(w, 2, 7, 8, 13); qround(w, 3, 4, 9, 14);
      end
    end
    for (int i = 0; i < 16; i++) ks_q[i] = w[i] + init[i];
    ctr_q = ctr_q + 64'd1;
  endtask

  function automatic int burst();
    return quiet ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0);
  endfunction

  // Sends one byte and records its expected cipher byte. The valid stays high
  // after the transaction so that a following byte can go out without a gap.
  task automatic send_byte(logic [7:0] data, logic start);
    logic [31:0] word;
    int gap;
    gap = burst();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (start) pos_q = '0;
    if (pos_q == 0) build_keystream_block();
    word = ks_q[pos_q[5:2]];
    expected_bytes.push_back(data ^ word[8*pos_q[1:0] +: 8]);
    pos_q = pos_q + 6'd1;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (BlockLat + 10) @(posedge clk_i);
  endtask

  // Registers are written only while nothing is in flight.
  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [63:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= RegNonce) begin
      if (idx == RegNonce) nonce_q = value;
      else key_q[idx] = value;
      ctr_q = '0;
      pos_q = '0;
    end
  endtask

  task automatic test_reset_key();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    for (int i = 0; i < 70; i++) send_byte(8'(i * 37), 1'b0);
  endtask

  task automatic test_extreme_key();
    write_reg(RegKey0, '1); write_reg(RegKey1, '1);
    write_reg(RegKey2, '1); write_reg(RegKey3, '1);
    write_reg(RegNonce, '1);
    send_byte(8'h55, 1'b1);
    send_byte(8'haa, 1'b0);
    send_byte(8'h0f, 1'b1);
    send_byte(8'hf0, 1'b0);
  endtask

  // An out-of-range index must leave the keystream running.
  task automatic test_bad_index();
    write_reg(3'd5, 64'hdead_beef_0000_1111);
    write_reg(3'd7, '1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
  endtask

  task automatic test_random();
    logic [63:0] v;
    for (int ph = 0; ph < 5; ph++) begin
      for (int r = 0; r < 5; r++) begin
        v = {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0) v = (ph % 2) ? '1 : '0;
        write_reg(RegIdxW'(r), v);
      end
      if (ph == 4) quiet = 1'b1;
      for (int i = 0; i < 380; i++)
        send_byte(8'($urandom), $urandom_range(0, 29) == 0);
    end
  endtask

  // Every third byte restarts the keystream with a fresh block.
  task automatic test_start_bursts();
    for (int i = 0; i < 40; i++) send_byte(8'($urandom), i % 3 == 0);
  endtask

  // The output side stalls in random bursts.
  always @(posedge clk_i) begin
    if (ready_gap > 0) begin
      ready_gap = ready_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      ready_gap = int'($urandom_range(1, 14)) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output byte %02h", m_axis_tdata);
      end else begin
        if (m_axis_tdata !== expected_bytes[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: expected %02h actual %02h",
                     expected_bytes[0], m_axis_tdata);
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Watchdog && !timed_out) begin
      timed_out = 1'b1;
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    mismatches = 0; idle_cycles = 0; quiet = 1'b0; timed_out = 1'b0;
    key_q = '{default: '0}; nonce_q = '0; ctr_q = '0; pos_q = '0;
    ks_q = '{default: '0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_key();
    test_extreme_key();
    test_bad_index();
    test_start_bursts();
    test_random();
    drain();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/chacha_pkg.sv
rtl/core/chacha_ctrl.sv
rtl/core/chacha_dp.sv
rtl/core/chacha20_stream_cipher.sv
verif/tb.sv
